@@ hw/rtl/rlee_pkg.sv @@
package rlee_pkg;

   localparam int MAX_GROUP_DEFAULT = 60;

   localparam logic [7:0] RUN_FLAG  = 8'h80;
   localparam logic [6:0] RUN_MAX   = 7'd127;
   localparam logic [6:0] RUN_START = 7'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TAKE,
      S_LA,
      S_RUN_HDR,
      S_RUN_VAL,
      S_FL_HDR,
      S_FL_DATA,
      S_END,
      S_FIN
   } state_type;

   typedef enum logic {
      RET_LA,
      RET_TAIL
   } ret_type;

endpackage

@@ hw/rtl/rlee_req_if.sv @@
interface rlee_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ hw/rtl/rlee_rsp_if.sv @@
interface rlee_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       code_last;

   modport source (output valid, output code_byte, output code_last, input ready);
   modport sink   (input valid, input code_byte, input code_last, output ready);
endinterface

@@ hw/rtl/rle_byte_encoder_unit.sv @@
// Run-length encoder for a byte stream, packbits style.
// req_ch takes one raw byte per request with last_byte marking stream end.
// rsp_ch delivers coded bytes: run header (0x80 | length) and value, or a
// literal header (count) followed by the literal bytes; code_last marks the
// final coded byte of the stream.
// Each request is accepted in S_IDLE and decided in S_TAKE; every coded
// byte takes its own step, and a run closed by a different byte returns
// to S_LA to place that byte. A literal flush emits its header, then its
// bytes through the single read port of the literal memory.
// A request with last_byte adds a drain through S_END plus its flush.
// Coded bytes always leave from the output register.
// Reset is synchronous: it drops pending output and returns to literal mode
// with empty lookahead and literal count; memory contents are not cleared.
// When the receiver stalls, the output register holds and the sequencer
// waits; req_ch.ready stays low until the current request is done.
module rle_byte_encoder_unit
   import rlee_pkg::*;
#(
   parameter int MAX_GROUP = MAX_GROUP_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   rlee_req_if.sink   req_ch,
   rlee_rsp_if.source rsp_ch
);

   localparam int CW = $clog2(MAX_GROUP + 1);
   localparam int AW = $clog2(MAX_GROUP);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_GROUP);

   state_type      state_ff, state_in;
   ret_type        ret_ff, ret_in;
   logic [7:0]     x_ff, x_in;
   logic           last_ff, last_in;
   logic           in_run_ff, in_run_in;
   logic [7:0]     rv_ff, rv_in;
   logic [6:0]     rl_ff, rl_in;
   logic [7:0]     la0_ff, la0_in;
   logic [7:0]     la1_ff, la1_in;
   logic [1:0]     la_cnt_ff, la_cnt_in;
   logic [CW-1:0]  lit_cnt_ff, lit_cnt_in;
   logic [AW-1:0]  k_ff, k_in;

   logic [7:0]     out_byte_ff, out_byte_in;
   logic           out_last_ff, out_last_in;
   logic           out_valid_ff, out_valid_in;
   logic [7:0]     pend_byte_ff, pend_byte_in;
   logic           pend_valid_ff, pend_valid_in;

   logic [7:0]     lit_mem [MAX_GROUP];
   logic [7:0]     rd_data_ff;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [7:0]     wr_data;
   logic [AW-1:0]  rd_addr;

   logic           can_emit;
   logic           emit_req;
   logic [7:0]     emit_byte;
   logic           fin_push;
   logic           do_la;
   state_type      tail_state;
   logic [CW-1:0]  lit_inc;
   logic [CW-1:0]  k_inc;
   logic [6:0]     rl_inc;
   logic           triple;
   logic           rsp_fire;

   assign rsp_fire = out_valid_ff && rsp_ch.ready;
   assign can_emit = !out_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.code_byte = out_byte_ff;
   assign rsp_ch.code_last = out_last_ff;

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      x_in       = x_ff;
      last_in    = last_ff;
      in_run_in  = in_run_ff;
      rv_in      = rv_ff;
      rl_in      = rl_ff;
      la0_in     = la0_ff;
      la1_in     = la1_ff;
      la_cnt_in  = la_cnt_ff;
      lit_cnt_in = lit_cnt_ff;
      k_in       = k_ff;
      emit_req   = 1'b0;
      emit_byte  = 8'h00;
      fin_push   = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = lit_cnt_ff[AW-1:0];
      wr_data    = la0_ff;
      rd_addr    = k_ff;
      req_ch.ready = 1'b0;
      do_la      = 1'b0;
      tail_state = last_ff ? S_END : S_IDLE;
      lit_inc    = lit_cnt_ff + CW'(1);
      k_inc      = CW'(k_ff) + CW'(1);
      rl_inc     = rl_ff + 7'd1;
      triple     = (la0_ff == la1_ff) && (la1_ff == x_ff);

      case (state_ff)
         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               x_in     = req_ch.data_byte;
               last_in  = req_ch.last_byte;
               state_in = S_TAKE;
            end
         end
         S_TAKE: begin
            if (in_run_ff) begin
               if (x_ff == rv_ff) begin
                  rl_in = rl_inc;
                  if (rl_inc == RUN_MAX) begin
                     state_in = S_RUN_HDR;
                     ret_in   = RET_TAIL;
                  end else begin
                     state_in = tail_state;
                  end
               end else begin
                  state_in = S_RUN_HDR;
                  ret_in   = RET_LA;
               end
            end else begin
               do_la = 1'b1;
            end
         end
         S_LA: begin
            do_la = 1'b1;
         end
         S_RUN_HDR: begin
            emit_req  = 1'b1;
            emit_byte = RUN_FLAG | {1'b0, rl_ff};
            if (can_emit) begin
               state_in = S_RUN_VAL;
            end
         end
         S_RUN_VAL: begin
            emit_req  = 1'b1;
            emit_byte = rv_ff;
            if (can_emit) begin
               in_run_in = 1'b0;
               rl_in     = 7'd0;
               state_in  = (ret_ff == RET_LA) ? S_LA : tail_state;
            end
         end
         S_FL_HDR: begin
            emit_req  = 1'b1;
            emit_byte = 8'(lit_cnt_ff);
            rd_addr   = '0;
            if (can_emit) begin
               k_in     = '0;
               state_in = S_FL_DATA;
            end
         end
         S_FL_DATA: begin
            emit_req  = 1'b1;
            emit_byte = rd_data_ff;
            if (can_emit) begin
               if (k_inc == lit_cnt_ff) begin
                  lit_cnt_in = '0;
                  state_in   = tail_state;
               end else begin
                  k_in    = k_ff + AW'(1);
                  rd_addr = k_ff + AW'(1);
               end
            end
         end
         S_END: begin
            if (in_run_ff) begin
               state_in = S_RUN_HDR;
               ret_in   = RET_TAIL;
            end else if (la_cnt_ff != 2'd0) begin
               wr_en      = 1'b1;
               lit_cnt_in = lit_inc;
               la0_in     = la1_ff;
               la_cnt_in  = la_cnt_ff - 2'd1;
               if (lit_inc == MAX_CNT) begin
                  state_in = S_FL_HDR;
               end
            end else if (lit_cnt_ff != '0) begin
               state_in = S_FL_HDR;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            fin_push = 1'b1;
            if (can_emit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (do_la) begin
         if (la_cnt_ff < 2'd2) begin
            if (la_cnt_ff == 2'd0) begin
               la0_in = x_ff;
            end else begin
               la1_in = x_ff;
            end
            la_cnt_in = la_cnt_ff + 2'd1;
            state_in  = tail_state;
         end else if (triple) begin
            in_run_in = 1'b1;
            rv_in     = x_ff;
            rl_in     = RUN_START;
            la_cnt_in = 2'd0;
            state_in  = (lit_cnt_ff != '0) ? S_FL_HDR : tail_state;
         end else begin
            wr_en      = 1'b1;
            lit_cnt_in = lit_inc;
            la0_in     = la1_ff;
            la1_in     = x_ff;
            state_in   = (lit_inc == MAX_CNT) ? S_FL_HDR : tail_state;
         end
      end
   end

   // output register, with a one-byte hold on the final request so the
   // closing byte can carry code_last
   always_comb begin
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff;
      pend_byte_in  = pend_byte_ff;
      pend_valid_in = pend_valid_ff;
      if (rsp_fire) begin
         out_valid_in = 1'b0;
      end
      if (emit_req && can_emit) begin
         if (last_ff) begin
            if (pend_valid_ff) begin
               out_byte_in  = pend_byte_ff;
               out_last_in  = 1'b0;
               out_valid_in = 1'b1;
            end
            pend_byte_in  = emit_byte;
            pend_valid_in = 1'b1;
         end else begin
            out_byte_in  = emit_byte;
            out_last_in  = 1'b0;
            out_valid_in = 1'b1;
         end
      end else if (fin_push && can_emit) begin
         out_byte_in   = pend_byte_ff;
         out_last_in   = 1'b1;
         out_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         in_run_ff     <= 1'b0;
         rl_ff         <= 7'd0;
         la_cnt_ff     <= 2'd0;
         lit_cnt_ff    <= '0;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         in_run_ff     <= in_run_in;
         rl_ff         <= rl_in;
         la_cnt_ff     <= la_cnt_in;
         lit_cnt_ff    <= lit_cnt_in;
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff       <= ret_in;
      x_ff         <= x_in;
      last_ff      <= last_in;
      rv_ff        <= rv_in;
      la0_ff       <= la0_in;
      la1_ff       <= la1_in;
      k_ff         <= k_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      pend_byte_ff <= pend_byte_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lit_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= lit_mem[rd_addr];
   end

`ifndef ASSERT_OFF
   a_fin_has_byte: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN |-> pend_valid_ff)
      else $error("final byte missing at stream end");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !pend_valid_ff && (lit_cnt_ff < MAX_CNT))
      else $error("held byte or full literal group left between requests");

   a_run_shape: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && in_run_ff |->
         la_cnt_ff == 2'd0 && rl_ff >= RUN_START && rl_ff < RUN_MAX)
      else $error("open run with lookahead or bad length");

   a_flush_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FL_DATA |-> lit_cnt_ff != '0)
      else $error("literal flush with empty group");
`endif

endmodule

@@ bench/rle_byte_encoder_unit_test.sv @@
`timescale 1ns / 1ps

typedef struct packed {
   logic [7:0] code_byte;
   logic       code_last;
} code_item_type;

class rle_code_scoreboard;
   code_item_type codes_due[$];
   logic [7:0]  literal_mem [rlee_pkg::MAX_GROUP_DEFAULT];
   int unsigned literal_fill;
   logic [7:0]  repeat_byte;
   int unsigned repeat_len;
   logic [7:0]  ahead_mem [2];
   int unsigned ahead_fill;
   bit          in_repeat;
   int unsigned errors;
   int unsigned checked;
   int unsigned run_groups;
   int unsigned full_runs;
   int unsigned literal_groups;
   int unsigned full_literals;

   function new();
      clear();
   endfunction

   function void clear();
      literal_fill = 0;
      repeat_byte  = 8'h00;
      repeat_len   = 0;
      ahead_mem[0] = 8'h00;
      ahead_mem[1] = 8'h00;
      ahead_fill   = 0;
      in_repeat    = 1'b0;
   endfunction

   function void put(logic [7:0] b);
      code_item_type c;
      c.code_byte = b;
      c.code_last = 1'b0;
      codes_due.push_back(c);
   endfunction

   function void flush_literal();
      if (literal_fill == 0) return;
      put(literal_fill[7:0]);
      for (int k = 0; k < literal_fill; k++) put(literal_mem[k]);
      literal_groups++;
      if (literal_fill == rlee_pkg::MAX_GROUP_DEFAULT) full_literals++;
      literal_fill = 0;
   endfunction

   function void push_literal(logic [7:0] b);
      if (literal_fill < rlee_pkg::MAX_GROUP_DEFAULT) begin
         literal_mem[literal_fill] = b;
         literal_fill++;
      end
      if (literal_fill >= rlee_pkg::MAX_GROUP_DEFAULT) flush_literal();
   endfunction

   function void close_run();
      logic [6:0] len;
      len = repeat_len[6:0];
      put(rlee_pkg::RUN_FLAG | {1'b0, len});
      put(repeat_byte);
      run_groups++;
      if (len == rlee_pkg::RUN_MAX) full_runs++;
      in_repeat  = 1'b0;
      repeat_len = 0;
   endfunction

   function void absorb(logic [7:0] x);
      logic [7:0] a;
      logic [7:0] b;
      if (in_repeat) begin
         if (x == repeat_byte) begin
            repeat_len++;
            if (repeat_len >= rlee_pkg::RUN_MAX) close_run();
            return;
         end
         close_run();
      end
      if (ahead_fill < 2) begin
         ahead_mem[ahead_fill] = x;
         ahead_fill++;
         return;
      end
      a = ahead_mem[0];
      b = ahead_mem[1];
      if (a == b && b == x) begin
         flush_literal();
         in_repeat   = 1'b1;
         repeat_byte = x;
         repeat_len  = 32'(rlee_pkg::RUN_START);
         ahead_fill  = 0;
      end else begin
         push_literal(a);
         ahead_mem[0] = b;
         ahead_mem[1] = x;
      end
   endfunction

   function void note_request(logic [7:0] b, logic fin);
      int unsigned   mark;
      code_item_type tail;
      mark = codes_due.size();
      absorb(b);
      if (fin) begin
         if (in_repeat) close_run();
         for (int k = 0; k < ahead_fill; k++) push_literal(ahead_mem[k]);
         ahead_fill = 0;
         flush_literal();
         if (codes_due.size() > mark) begin
            tail = codes_due.pop_back();
            tail.code_last = 1'b1;
            codes_due.push_back(tail);
         end
         clear();
      end
   endfunction

   function void check_code(logic [7:0] b, logic fin);
      code_item_type want;
      if (codes_due.size() == 0) begin
         errors++;
         $error("code_byte: expected none, actual %02h (code_last %0b)", b, fin);
         return;
      end
      want = codes_due.pop_front();
      checked++;
      if (b !== want.code_byte) begin
         errors++;
         $error("code_byte: expected %02h, actual %02h", want.code_byte, b);
      end
      if (fin !== want.code_last) begin
         errors++;
         $error("code_last: expected %0b, actual %0b", want.code_last, fin);
      end
   endfunction
endclass

module rle_byte_encoder_unit_test;
   import rlee_pkg::*;

   localparam int GROUP_SIZE     = MAX_GROUP_DEFAULT;
   localparam int RANDOM_ITEMS   = 410;
   localparam int HOLD_CYCLES    = 600;
   localparam int HOLD_AFTER     = 150;
   localparam int DRAIN_CYCLES   = 40;

   typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_type;
   typedef enum int {SEG_RUN, SEG_LONG_RUN, SEG_LITERAL, SEG_LONG_LITERAL} seg_kind_type;

   logic clock;
   logic reset;

   rlee_req_if req_ch ();
   rlee_rsp_if rsp_ch ();

   rle_byte_encoder_unit #(.MAX_GROUP(GROUP_SIZE)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   rle_code_scoreboard sb = new();

   int unsigned burst_left;
   int unsigned requests_sent;
   int unsigned streams_sent;
   bit          need_long_run;
   bit          need_long_literal;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

   task automatic send_request(input logic [7:0] b, input logic fin);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= fin;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_request(b, fin);
      requests_sent++;
   endtask

   task automatic send_stream(input logic [7:0] bytes[$]);
      for (int k = 0; k < bytes.size(); k++) send_request(bytes[k], k == bytes.size() - 1);
      streams_sent++;
   endtask

   task automatic random_stream();
      logic [7:0]   bytes[$];
      int           segs;
      int           len;
      int           pick;
      seg_kind_type kind;
      logic [7:0]   v;
      if ($urandom_range(0, 9) == 0) begin
         len = $urandom_range(1, 4);
         for (int k = 0; k < len; k++) bytes.push_back(8'($urandom_range(0, 255)));
         send_stream(bytes);
         return;
      end
      segs = $urandom_range(1, 5);
      for (int s = 0; s < segs; s++) begin
         pick = $urandom_range(0, 99);
         if (need_long_run) kind = SEG_LONG_RUN;
         else if (need_long_literal) kind = SEG_LONG_LITERAL;
         else if (pick < 2) kind = SEG_LONG_RUN;
         else if (pick < 4) kind = SEG_LONG_LITERAL;
         else if (pick < 50) kind = SEG_RUN;
         else kind = SEG_LITERAL;
         v = 8'($urandom_range(0, 255));
         case (kind)
            SEG_RUN: begin
               len = $urandom_range(1, 10);
               repeat (len) bytes.push_back(v);
            end
            SEG_LONG_RUN: begin
               need_long_run = 1'b0;
               len = ($urandom_range(0, 2) == 0) ? int'(RUN_MAX)
                                                 : int'($urandom_range(120, 136));
               repeat (len) bytes.push_back(v);
            end
            SEG_LITERAL: begin
               len = $urandom_range(1, 12);
               for (int k = 0; k < len; k++) begin
                  if ($urandom_range(0, 1)) bytes.push_back(8'(v + $urandom_range(0, 2)));
                  else bytes.push_back(8'($urandom_range(0, 255)));
               end
            end
            default: begin
               need_long_literal = 1'b0;
               len = $urandom_range(GROUP_SIZE - 2, GROUP_SIZE + 6);
               for (int k = 0; k < len; k++) bytes.push_back(8'(v + k));
            end
         endcase
      end
      send_stream(bytes);
   endtask

   initial begin
      rx_mode_type rx_mode;
      int unsigned mode_left;
      int unsigned hold_left;
      bit          hold_done;
      rsp_ch.ready <= 1'b0;
      mode_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_code(rsp_ch.code_byte, rsp_ch.code_last);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!hold_done && sb.checked >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               rx_mode   = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(8, 80);
            end
            mode_left--;
            case (rx_mode)
               RX_OPEN:   rsp_ch.ready <= 1'b1;
               RX_HALF:   rsp_ch.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   initial begin
      logic [7:0] stream[$];
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.data_byte  <= 8'h00;
      req_ch.last_byte  <= 1'b0;
      burst_left        = 0;
      requests_sent     = 0;
      streams_sent      = 0;
      need_long_run     = 1'b1;
      need_long_literal = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      stream = '{8'h00};
      send_stream(stream);
      stream = '{8'hFF};
      send_stream(stream);
      stream = '{8'hAA, 8'h55};
      send_stream(stream);
      stream = '{8'h7E, 8'h7E, 8'h7E};
      send_stream(stream);
      stream = '{8'h33, 8'h33, 8'h33, 8'h33, 8'hC4};
      send_stream(stream);
      stream = '{8'h10, 8'h20, 8'h30, 8'h30, 8'h30, 8'h30};
      send_stream(stream);
      stream = '{8'h5A, 8'hA5, 8'h5A, 8'hA5, 8'hFF};
      send_stream(stream);

      requests_sent = 0;
      while (requests_sent < RANDOM_ITEMS) random_stream();
      req_ch.valid <= 1'b0;

      while (sb.codes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d streams and %0d random requests; %0d coded bytes checked.",
               streams_sent, requests_sent, sb.checked);
      $display("Saw %0d runs (%0d at full length) and %0d literal groups (%0d full).",
               sb.run_groups, sb.full_runs, sb.literal_groups, sb.full_literals);
      if (sb.errors == 0 && sb.codes_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
